@@ rtl/wavetable_oscillator_interp_assert.svh @@
// ----------------------------------------------------------------------------
// wavetable oscillator assertion macros
// shared check forms for the oscillator's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef WAVETABLE_OSCILLATOR_INTERP_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_INTERP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define WOI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wavetable oscillator check failed");

// consequent holds in the cycle after the antecedent
`define WOI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wavetable oscillator check failed");

`endif

@@ rtl/woi_pkg.sv @@
// ----------------------------------------------------------------------------
// wavetable oscillator package
// field types and function codes shared by the channels and the core
// ----------------------------------------------------------------------------
package woi_pkg;

   // item field types
   typedef logic               func_type;
   typedef logic [2:0]         channel_type;
   typedef logic [10:0]        table_index_type;
   typedef logic signed [15:0] table_word_type;
   typedef logic [31:0]        phase_type;
   typedef logic signed [15:0] gain_type;
   typedef logic signed [23:0] bus_sample_type;

   // function codes
   localparam func_type FUNC_LOAD   = 1'b0;
   localparam func_type FUNC_SAMPLE = 1'b1;

   // gain and output limits
   localparam gain_type       GAIN_RESET = 16'sd4096;
   localparam gain_type       GAIN_MAX   = 16'sh7FFF;
   localparam gain_type       GAIN_MIN   = 16'sh8000;
   localparam bus_sample_type BUS_MAX    = 24'sh7FFFFF;
   localparam bus_sample_type BUS_MIN    = 24'sh800000;

endpackage

@@ rtl/woi_req_if.sv @@
// ----------------------------------------------------------------------------
// wavetable oscillator request channel
// valid/ready channel carrying one load or sample item
// ----------------------------------------------------------------------------
interface woi_req_if;
   import woi_pkg::*;

   logic            valid;
   logic            ready;
   func_type        func;
   channel_type     channel;
   table_index_type table_index;
   table_word_type  table_value;
   phase_type       phase_step;
   gain_type        amp_mod;
   bus_sample_type  mix_in;

   modport source (
      output valid, func, channel, table_index, table_value,
             phase_step, amp_mod, mix_in,
      input  ready
   );

   modport sink (
      input  valid, func, channel, table_index, table_value,
             phase_step, amp_mod, mix_in,
      output ready
   );
endinterface

@@ rtl/woi_rsp_if.sv @@
// ----------------------------------------------------------------------------
// wavetable oscillator response channel
// valid/ready channel carrying one output sample item
// ----------------------------------------------------------------------------
interface woi_rsp_if;
   import woi_pkg::*;

   logic           valid;
   logic           ready;
   channel_type    channel_out;
   bus_sample_type sample_out;

   modport source (
      output valid, channel_out, sample_out,
      input  ready
   );

   modport sink (
      input  valid, channel_out, sample_out,
      output ready
   );
endinterface

@@ rtl/wavetable_oscillator_interp.sv @@
// A sample item passes through S_PH, S_A, S_B, S_M1, S_M2 and S_FIN, which holds
// while rsp is stalled, before it shows on rsp. The single table read port (two
// reads) and the one shared 17x17 multiplier (two products) serve one item at a time.
// Load items and ignored channels are taken one per cycle while the sequencer is idle.
// Reset: phases read as zero, base gain 1.0 (Q4.12), table contents undefined
// until written; there is no clearing pass.
// ----------------------------------------------------------------------------
// wavetable oscillator with linear interpolation
// multi-channel phase accumulators, shared wave table, one shared multiplier
// ----------------------------------------------------------------------------
`include "wavetable_oscillator_interp_assert.svh"

module wavetable_oscillator_interp #(
   parameter int TABLE_LENGTH = 2048,
   parameter int CHANNELS     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  woi_pkg::gain_type csr_wdata,
   woi_req_if.sink          req_ch,
   woi_rsp_if.source        rsp_ch
);
   import woi_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_LENGTH);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PH   = 3'd1;
   localparam logic [2:0] S_A    = 3'd2;
   localparam logic [2:0] S_B    = 3'd3;
   localparam logic [2:0] S_M1   = 3'd4;
   localparam logic [2:0] S_M2   = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]           state_ff, state_in;
   gain_type             base_ff;
   channel_type          ch_ff;
   logic [CH_W-1:0]      ph_idx_ff;
   phase_type            inc_ff;
   bus_sample_type       mix_ff;
   gain_type             gain_ff;
   logic [15:0]          frac_ff;
   logic [ADDR_W-1:0]    i0_ff;
   table_word_type       a_ff;
   table_word_type       interp_ff;
   logic signed [33:0]   mul_ff;
   logic                 out_valid_ff;
   channel_type          out_ch_ff;
   bus_sample_type       out_sample_ff;
   logic [CHANNELS-1:0]  ph_valid_ff;

   // memories
   table_word_type       wave_mem [TABLE_LENGTH];
   phase_type            ph_mem   [CHANNELS];
   table_word_type       tbl_rd_ff;
   phase_type            ph_rd_ff;

   logic                 acc;
   logic                 ch_ok;
   logic                 tbl_we;
   logic [ADDR_W-1:0]    tbl_raddr;
   logic [CH_W-1:0]      req_ph_idx;
   phase_type            ph_new;
   phase_type            ph_shift;
   logic signed [16:0]   gain_sum;
   gain_type             gain_sat;
   logic signed [16:0]   mul_x, mul_y;
   logic signed [33:0]   mul_prod;
   logic signed [33:0]   rnd;
   logic signed [25:0]   sum_wide;
   bus_sample_type       sum_sat;
   logic                 out_free;

   // request handshake
   assign req_ch.ready = (state_ff == S_IDLE);
   assign acc          = req_ch.valid && req_ch.ready;
   assign ch_ok        = (32'(req_ch.channel) < CHANNELS);
   assign tbl_we       = acc && (req_ch.func == FUNC_LOAD);
   assign req_ph_idx   = CH_W'(req_ch.channel);

   // gain from base plus modulation, saturated to 16 bits
   assign gain_sum = 17'(base_ff) + 17'(req_ch.amp_mod);
   always_comb begin
      if (gain_sum > 17'sd32767) begin
         gain_sat = GAIN_MAX;
      end else if (gain_sum < -17'sd32768) begin
         gain_sat = GAIN_MIN;
      end else begin
         gain_sat = gain_sum[15:0];
      end
   end

   // phase advance and table position
   assign ph_new   = (ph_valid_ff[ph_idx_ff] ? ph_rd_ff : '0) + inc_ff;
   assign ph_shift = ph_new << ADDR_W;
   assign tbl_raddr = (state_ff == S_PH) ? ph_new[31 -: ADDR_W] : ADDR_W'(i0_ff + 1'b1);

   // shared multiplier operand select
   always_comb begin
      if (state_ff == S_B) begin
         mul_x = 17'(tbl_rd_ff) - 17'(a_ff);
         mul_y = $signed({1'b0, frac_ff});
      end else begin
         mul_x = 17'(gain_ff);
         mul_y = 17'(interp_ff);
      end
   end
   assign mul_prod = mul_x * mul_y;

   // rounding and output saturation
   assign rnd      = mul_ff + 34'sd2048;
   assign sum_wide = 26'(mix_ff) + 26'($signed(rnd[33:12]));
   always_comb begin
      if (sum_wide > 26'(BUS_MAX)) begin
         sum_sat = BUS_MAX;
      end else if (sum_wide < 26'(BUS_MIN)) begin
         sum_sat = BUS_MIN;
      end else begin
         sum_sat = sum_wide[23:0];
      end
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc && req_ch.func == FUNC_SAMPLE && ch_ok) begin
               state_in = S_PH;
            end
         end
         S_PH:   state_in = S_A;
         S_A:    state_in = S_B;
         S_B:    state_in = S_M1;
         S_M1:   state_in = S_M2;
         S_M2:   state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= GAIN_RESET;
         out_valid_ff <= 1'b0;
         ph_valid_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            base_ff <= csr_wdata;
         end
         if (state_ff == S_PH) begin
            ph_valid_ff[ph_idx_ff] <= 1'b1;
         end
         if (state_ff == S_FIN && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (acc) begin
         ch_ff     <= req_ch.channel;
         ph_idx_ff <= req_ph_idx;
         inc_ff    <= req_ch.phase_step;
         mix_ff    <= req_ch.mix_in;
         gain_ff   <= gain_sat;
      end
      if (state_ff == S_PH) begin
         i0_ff   <= ph_new[31 -: ADDR_W];
         frac_ff <= ph_shift[31:16];
      end
      if (state_ff == S_A) begin
         a_ff <= tbl_rd_ff;
      end
      if (state_ff == S_B || state_ff == S_M2) begin
         mul_ff <= mul_prod;
      end
      // interpolated word stays between the two table entries
      if (state_ff == S_M1) begin
         interp_ff <= a_ff + mul_ff[31:16];
      end
      if (state_ff == S_FIN && out_free) begin
         out_ch_ff     <= ch_ff;
         out_sample_ff <= sum_sat;
      end
   end

   // wave table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         wave_mem[ADDR_W'(req_ch.table_index)] <= req_ch.table_value;
      end
      tbl_rd_ff <= wave_mem[tbl_raddr];
   end

   // phase store, written back once per sample item
   always_ff @(posedge clock) begin
      if (state_ff == S_PH) begin
         ph_mem[ph_idx_ff] <= ph_new;
      end
      ph_rd_ff <= ph_mem[req_ph_idx];
   end

   // response channel
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.channel_out = out_ch_ff;
   assign rsp_ch.sample_out  = out_sample_ff;

   // checks
   `WOI_ASSERT_NEXT(a_sample_starts, clock, reset,
      acc && req_ch.func == FUNC_SAMPLE && ch_ok, state_ff == S_PH)
   `WOI_ASSERT_NEXT(a_load_stays_idle, clock, reset,
      acc && req_ch.func == FUNC_LOAD, state_ff == S_IDLE)
   `WOI_ASSERT_NEXT(a_finish_delivers, clock, reset,
      state_ff == S_FIN && out_free, out_valid_ff && state_ff == S_IDLE)

endmodule
